// ===== hw/rtl/bdq_pkg.sv =====
// Shared types and constants of the bit deque engine.
package bdq_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned POS_W    = 10;
    localparam int unsigned LEN_W    = 11;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ       = 3'd4,
        OP_WRITE      = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

endpackage

// ===== hw/rtl/bdq_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
module bdq_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bit_deque_engine.sv =====
// Top level of the bit deque engine: pointer logic around a one-bit-wide store.
//
// A double-ended queue of single bits. Each input item carries one operation
// (push back, push front, pop back, pop front, read at an index counted from
// the front, or write at such an index) together with a position and a bit.
// Every item gives exactly one result item: the bit read (zero for any other
// operation or for a failed read), a status code and the length afterwards.
//
// Both channels use valid and ready. An input item is decided in the cycle it
// is accepted: the head pointer and count update at that edge, a push or write
// stores its bit in the RAM at that edge, and a read addresses the RAM at that
// edge. The result appears in the next cycle, with the read bit taken straight
// from the RAM's output register. The block sustains one item per cycle while
// the receiver takes each result; the single RAM port pair and the registered
// RAM read port set that figure.
//
// The result register holds its item while the receiver stalls, and input is
// accepted whenever that register is empty or is being emptied in the same
// cycle. Reset clears the head pointer, the count and the result valid flag;
// the store itself is not cleared, since only positions inside the queue are
// ever read and each of those was written by a push or a write.
module bit_deque_engine #(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bdq_pkg::OP_W-1:0]      i_op,
    input  logic [bdq_pkg::POS_W-1:0]     i_position,
    input  logic                          i_bit_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_bit_out,
    output logic [bdq_pkg::STATUS_W-1:0]  o_status,
    output logic [bdq_pkg::LEN_W-1:0]     o_length
);

    localparam int unsigned PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned SUM_W = CNT_W + 1;
    localparam int unsigned CMP_W = (CNT_W > bdq_pkg::POS_W) ? CNT_W : bdq_pkg::POS_W;

    localparam logic [CNT_W-1:0] CAP_CNT     = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_M1_CNT  = CNT_W'(CAPACITY - 1);
    localparam logic [SUM_W-1:0] CAP_SUM     = SUM_W'(CAPACITY);

    logic [PTR_W-1:0] r_head,  n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    logic             r_is_read;
    logic [bdq_pkg::STATUS_W-1:0] r_status;

    logic                   accept;
    logic [CNT_W-1:0]       offset;
    logic [SUM_W-1:0]       slot_sum;
    logic [PTR_W-1:0]       slot;
    logic                   mem_we;
    logic                   mem_re;
    logic                   mem_rdata;
    bdq_pkg::t_status       status;
    logic                   pos_ok;
    logic                   is_full;
    logic                   is_empty;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign is_full  = (r_count >= CAP_CNT);
    assign is_empty = (r_count == '0);
    assign pos_ok   = (CMP_W'(i_position) < CMP_W'(r_count));

    // Circular addressing: head plus an offset below the capacity wraps with
    // one compare and subtract.
    assign slot_sum = SUM_W'(r_head) + SUM_W'(offset);
    assign slot     = (slot_sum >= CAP_SUM) ? PTR_W'(slot_sum - CAP_SUM) : PTR_W'(slot_sum);

    always_comb begin
        offset  = CNT_W'(i_position);
        n_head  = r_head;
        n_count = r_count;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        status  = bdq_pkg::ST_OK;
        case (i_op)
            bdq_pkg::OP_PUSH_BACK: begin
                offset = r_count;
                if (is_full) begin
                    status = bdq_pkg::ST_FULL;
                end else begin
                    mem_we  = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            bdq_pkg::OP_PUSH_FRONT: begin
                offset = CAP_M1_CNT;
                if (is_full) begin
                    status = bdq_pkg::ST_FULL;
                end else begin
                    mem_we  = 1'b1;
                    n_head  = slot;
                    n_count = r_count + 1'b1;
                end
            end
            bdq_pkg::OP_POP_BACK: begin
                if (is_empty) begin
                    status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            bdq_pkg::OP_POP_FRONT: begin
                offset = CNT_W'(1);
                if (is_empty) begin
                    status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_head  = slot;
                    n_count = r_count - 1'b1;
                end
            end
            bdq_pkg::OP_READ: begin
                if (!pos_ok) begin
                    status = bdq_pkg::ST_RANGE;
                end else begin
                    mem_re = 1'b1;
                end
            end
            bdq_pkg::OP_WRITE: begin
                if (!pos_ok) begin
                    status = bdq_pkg::ST_RANGE;
                end else begin
                    mem_we = 1'b1;
                end
            end
            default: begin
                status = bdq_pkg::ST_RANGE;
            end
        endcase
    end

    bdq_ram #(
        .WIDTH (1),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && mem_we),
        .i_waddr (slot),
        .i_wdata (i_bit_in),
        .i_re    (accept && mem_re),
        .i_raddr (slot),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head      <= n_head;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; the read bit itself stays in the RAM's output register,
    // which no other item disturbs until this result has been taken.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_read <= mem_re;
            r_status  <= status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bit_out   = r_is_read & mem_rdata;
    assign o_status    = r_status;
    assign o_length    = bdq_pkg::LEN_W'(r_count);

endmodule

// ===== hw/rtl/bdq_checker.sv =====
// Port-level assertions for the bit deque engine and the bind that attaches them.
module bdq_checker #(
    parameter int unsigned CAPACITY = 1024
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_bit_out,
    input logic [bdq_pkg::STATUS_W-1:0]  o_status,
    input logic [bdq_pkg::LEN_W-1:0]     o_length
);

    localparam logic [bdq_pkg::LEN_W-1:0] CAP_LEN = bdq_pkg::LEN_W'(CAPACITY);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_bit_out)
            && $stable(o_status) && $stable(o_length))
        else $error("result item changed or dropped while stalled");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == bdq_pkg::ST_EMPTY |-> o_length == '0)
        else $error("empty status with a non-zero length");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == bdq_pkg::ST_FULL |-> o_length == CAP_LEN)
        else $error("full status below capacity");

    a_bit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bit_out |-> o_status == bdq_pkg::ST_OK)
        else $error("bit returned by a failed operation");

endmodule

bind bit_deque_engine bdq_checker #(
    .CAPACITY (CAPACITY)
) u_bdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_bit_out   (o_bit_out),
    .o_status    (o_status),
    .o_length    (o_length)
);
